// ----- hdl/pfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfsc_pkg: shared types and codes for the PCM/float sample converter
// Transaction payload structs, command, register index and width codes.
// ----------------------------------------------------------------------------
package pfsc_pkg;

	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_ENCODE = 1'b1;

	localparam logic [1:0] REG_WIDTH_CODE = 2'd0;
	localparam logic [1:0] REG_IS_SIGNED  = 2'd1;
	localparam logic [1:0] REG_BIG_ENDIAN = 2'd2;

	localparam logic [1:0] W8  = 2'd0;
	localparam logic [1:0] W16 = 2'd1;
	localparam logic [1:0] W24 = 2'd2;
	localparam logic [1:0] W32 = 2'd3;

	typedef struct packed {
		logic        command;
		logic [31:0] sample_data;
	} sample_t;

	typedef struct packed {
		logic [31:0] result_data;
		logic        format_error;
	} result_t;

endpackage

// ----- hdl/pcm_float_sample_converter.sv -----
// ----------------------------------------------------------------------------
// pcm_float_sample_converter: PCM bytes <-> IEEE single float, one sample each
// Two register stages: input register, conversion logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: sample_valid / sample_stall / sample. A transaction moves
//     when sample_valid is high and sample_stall is low. command selects
//     decode (bytes to float) or encode (float to bytes).
//   result channel: result_valid / result_stall / result, same rule.
//   Configuration: cfg_we, cfg_index, cfg_wdata; write only while idle.
//     Index 0 width code, 1 signed flag, 2 big endian flag.
// Flow: an accepted sample enters the input register; result_valid rises
//   once the input register has passed it on to the result register.
// Throughput: one sample per cycle unless stalled; the single-pass conversion
//   cone between the input register and the result register sets that figure.
// Reset: both stages empty, width code 16-bit, signed, little endian.
// Stall: when the result register is full and stalled, both stages hold and
//   sample_stall rises in the same cycle; data is never dropped.
// ----------------------------------------------------------------------------
module pcm_float_sample_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  pfsc_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_stall,
	output pfsc_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [1:0]        cfg_wdata
);
	import pfsc_pkg::*;

	logic [1:0] width_code_q;
	logic       is_signed_q;
	logic       big_endian_q;

	logic    valid_s1;
	sample_t data_s1;
	result_t data_s2;
	result_t conv;
	logic    adv;

	// Reorder the low bytes of a sample, zero above the width.
	function automatic logic [31:0] swap_bytes(logic [31:0] r, logic [1:0] w);
		logic [31:0] o;
		case (w)
			W16:     o = {16'd0, r[7:0], r[15:8]};
			W24:     o = {8'd0, r[7:0], r[15:8], r[23:16]};
			W32:     o = {r[7:0], r[15:8], r[23:16], r[31:24]};
			default: o = r;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] width_mask(logic [1:0] w);
		logic [31:0] m;
		case (w)
			W8:      m = 32'h0000_00FF;
			W16:     m = 32'h0000_FFFF;
			W24:     m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] decode(logic [31:0] d, logic [1:0] w,
		logic sgn, logic be);
		logic [31:0] mask;
		logic [31:0] raw;
		logic [31:0] mag;
		logic [31:0] keep;
		logic [31:0] rem;
		logic [31:0] half;
		logic [4:0]  p;
		logic [3:0]  s;
		logic [7:0]  ex;
		logic        neg;
		mask = width_mask(w);
		raw  = d & mask;
		if (be)
			raw = swap_bytes(raw, w);
		if (!sgn)
			raw = raw ^ 32'h80;
		case (w)
			W8:      neg = raw[7];
			W16:     neg = raw[15];
			W24:     neg = raw[23];
			default: neg = raw[31];
		endcase
		mag = neg ? ((~raw + 32'd1) & mask) : raw;
		p = 5'd0;
		for (int i = 1; i < 32; i++)
			if (mag[i])
				p = 5'(i);
		if (mag == 32'd0)
			return 32'd0;
		if (p <= 5'd23) begin
			keep = mag << (5'd23 - p);
		end else begin
			s    = 4'(p - 5'd23);
			keep = mag >> s;
			rem  = mag & ((32'd1 << s) - 32'd1);
			half = 32'd1 << (s - 4'd1);
			if (rem > half || (rem == half && keep[0]))
				keep = keep + 32'd1;
			if (keep[24]) begin
				keep = keep >> 1;
				p    = p + 5'd1;
			end
		end
		ex = 8'(p) + 8'd120 - {3'd0, w, 3'd0};
		return {neg, ex, keep[22:0]};
	endfunction

	function automatic logic [31:0] encode(logic [31:0] d, logic [1:0] w,
		logic sgn, logic be);
		logic [7:0]  ef;
		logic [8:0]  bexp;
		logic [31:0] key;
		logic [31:0] lim;
		logic [23:0] m;
		logic [24:0] y;
		logic [4:0]  sh;
		logic [31:0] mag;
		logic [31:0] v;
		logic [31:0] raw;
		logic        neg;
		ef   = d[30:23];
		neg  = d[31];
		m    = {1'b1, d[22:0]};
		bexp = {1'b0, ef} + {4'd0, w, 3'd7};
		key  = {bexp, d[22:0]};
		case (w)
			W8:      lim = neg ? 32'h4300_0000 : 32'h42FE_0000;
			W16:     lim = neg ? 32'h4700_0000 : 32'h46FF_FE00;
			W24:     lim = neg ? 32'h4B00_0000 : 32'h4AFF_FFFE;
			default: lim = 32'h4F00_0000;
		endcase
		mag = 32'd0;
		if (ef == 8'hFF && d[22:0] != 23'd0) begin
			v = 32'd0;
		end else if (ef == 8'd0) begin
			v = 32'd0;
		end else if (key >= lim) begin
			// saturate at the integer limits
			case (w)
				W8:      v = neg ? 32'hFFFF_FF80 : 32'h0000_007F;
				W16:     v = neg ? 32'hFFFF_8000 : 32'h0000_7FFF;
				W24:     v = neg ? 32'hFF80_0000 : 32'h007F_FFFF;
				default: v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			endcase
		end else begin
			if (bexp < 9'd126) begin
				// below one half: only the largest float under 0.5 rounds up
				mag = (key == 32'h3EFF_FFFF) ? 32'd1 : 32'd0;
			end else if (bexp <= 9'd149) begin
				sh = 5'(9'd150 - bexp);
				y  = {1'b0, m} + (25'd1 << (sh - 5'd1));
				// carry into a new binade drops one bit: round to even
				if (y[24] && y[0])
					y = y[1] ? y + 25'd1 : y - 25'd1;
				mag = 32'(y >> sh);
			end else if (bexp == 9'd150) begin
				mag = {8'd0, m} + {31'd0, m[0]};
			end else begin
				mag = {8'd0, m} << 3'(bexp - 9'd150);
			end
			v = neg ? (~mag + 32'd1) : mag;
		end
		raw = v & width_mask(w);
		if (!sgn)
			raw = raw ^ 32'h80;
		if (be)
			raw = swap_bytes(raw, w);
		return raw;
	endfunction

	// Advance both stages unless a finished result is held by the receiver.
	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q <= W16;
			is_signed_q  <= 1'b1;
			big_endian_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_CODE: width_code_q <= cfg_wdata;
				REG_IS_SIGNED:  is_signed_q  <= cfg_wdata[0];
				REG_BIG_ENDIAN: big_endian_q <= cfg_wdata[0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		conv.format_error = 1'b0;
		if (!is_signed_q && width_code_q != W8) begin
			conv.result_data  = 32'd0;
			conv.format_error = 1'b1;
		end else if (data_s1.command == CMD_ENCODE) begin
			conv.result_data = encode(data_s1.sample_data, width_code_q,
				is_signed_q, big_endian_q);
		end else begin
			conv.result_data = decode(data_s1.sample_data, width_code_q,
				is_signed_q, big_endian_q);
		end
	end

	// Hold control in reset; payload needs none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			valid_s1     <= sample_valid;
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= sample;
			data_s2 <= conv;
		end
	end

	assign result = data_s2;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.format_error |-> result.result_data == 32'd0)
		else $error("format error with nonzero data");
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv |=> result_valid)
		else $error("stage one item lost");
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("stall with empty result register");
`endif

endmodule
